// ===== rtl/bcaf_pkg.sv =====
// shared types and constants for the block commit audio fifo
package bcaf_pkg;

	localparam int CAPACITY_FRAMES = 2048;
	localparam int BLOCK_FRAMES    = 256;

	localparam int SLOT_W   = $clog2(CAPACITY_FRAMES);
	localparam int POS_W    = $clog2(2 * CAPACITY_FRAMES);
	localparam int STAGED_W = $clog2(BLOCK_FRAMES + 1);
	localparam int SAMPLE_W = 16;
	localparam int WORD_W   = 2 * SAMPLE_W;
	localparam int COUNT_W  = 32;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_FAULT = 2'd2
	} action_t;

	typedef struct packed {
		logic               valid;
		logic               accepted;
		logic               popped;
		logic               refill;
		logic               ready;
		logic               failed;
		logic [POS_W-1:0]   buffered;
		logic [COUNT_W-1:0] underruns;
	} result_t;

endpackage

// ===== rtl/bcaf_ram.sv =====
// frame store: one write port, one read port with registered read data
module bcaf_ram
	import bcaf_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [SLOT_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [CAPACITY_FRAMES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/bcaf_ctrl.sv =====
// pointer, staging, latch and underrun logic with the result register
module bcaf_ctrl
	import bcaf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [1:0]        action_s1,
	input  logic [WORD_W-1:0] frame_s1,
	output logic              we,
	output logic [SLOT_W-1:0] waddr,
	output logic [WORD_W-1:0] wdata,
	output logic              re,
	output logic [SLOT_W-1:0] raddr,
	output result_t           result_s2
);

	logic [POS_W-1:0]    rp_q, cp_q;
	logic [STAGED_W-1:0] staged_q;
	logic                ready_q, fault_q;
	logic [COUNT_W-1:0]  under_q;

	logic [POS_W-1:0]    rp_d, cp_d, used, used_d, free_frames;
	logic [STAGED_W-1:0] staged_d, staged_inc;
	logic                ready_d, fault_d;
	logic [COUNT_W-1:0]  under_d;
	logic                push_ok, pop_go, pop_ok, refill;
	result_t             result_d;

	assign used        = cp_q - rp_q;
	assign free_frames = POS_W'(CAPACITY_FRAMES) - used;
	assign staged_inc  = staged_q + STAGED_W'(1);

	always_comb begin
		rp_d     = rp_q;
		cp_d     = cp_q;
		staged_d = staged_q;
		ready_d  = ready_q;
		fault_d  = fault_q;
		under_d  = under_q;
		push_ok  = 1'b0;
		pop_go   = 1'b0;
		pop_ok   = 1'b0;
		refill   = 1'b0;
		if (valid_s1) begin
			case (action_t'(action_s1))
				ACT_PUSH: begin
					push_ok = !fault_q && !(staged_q == '0 &&
						free_frames < POS_W'(BLOCK_FRAMES));
					if (push_ok) begin
						if (staged_inc >= STAGED_W'(BLOCK_FRAMES)) begin
							staged_d = '0;
							cp_d     = cp_q + POS_W'(BLOCK_FRAMES);
							if (used + POS_W'(BLOCK_FRAMES) == POS_W'(CAPACITY_FRAMES)) begin
								ready_d = 1'b1;
							end
						end else begin
							staged_d = staged_inc;
						end
					end
				end
				ACT_POP: begin
					pop_go = ready_q && !fault_q;
					pop_ok = pop_go && used != '0;
					if (pop_ok) begin
						rp_d   = rp_q + POS_W'(1);
						refill = (rp_d % POS_W'(BLOCK_FRAMES)) == '0;
					end else if (pop_go && under_q != '1) begin
						under_d = under_q + COUNT_W'(1);
					end
				end
				ACT_FAULT: begin
					fault_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
		used_d = cp_d - rp_d;
	end

	assign we    = push_ok;
	assign waddr = cp_q[SLOT_W-1:0] + SLOT_W'(staged_q);
	assign wdata = frame_s1;
	assign re    = pop_ok;
	assign raddr = rp_q[SLOT_W-1:0];

	always_comb begin
		result_d.valid     = valid_s1;
		result_d.accepted  = push_ok || pop_ok;
		result_d.popped    = pop_ok;
		result_d.refill    = refill;
		result_d.ready     = ready_d && !fault_d;
		result_d.failed    = fault_d;
		result_d.buffered  = used_d;
		result_d.underruns = under_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			cp_q      <= '0;
			staged_q  <= '0;
			ready_q   <= 1'b0;
			fault_q   <= 1'b0;
			under_q   <= '0;
			result_s2 <= '0;
		end else begin
			rp_q      <= rp_d;
			cp_q      <= cp_d;
			staged_q  <= staged_d;
			ready_q   <= ready_d;
			fault_q   <= fault_d;
			under_q   <= under_d;
			result_s2 <= result_d;
		end
	end

endmodule

// ===== rtl/block_commit_audio_fifo.sv =====
// top level of the block commit stereo audio fifo
// Takes one word per clock: busy is never raised, so a command is accepted at
// every edge where start is high. Each command produces exactly one result word,
// marked by done, which rises at the clock edge after the accepting edge: the input
// register loads at the accepting edge, and then the result register and the frame
// store read register load. The frame store is a 2048 x 32 memory with one
// write and one read port; pushes write, pops read, and the pointers and latches
// update in the same cycle so the next command sees them.
// Results cannot be held off: done is high for one cycle per word.
module block_commit_audio_fifo
	import bcaf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic signed [SAMPLE_W-1:0] left_in,
	input  logic signed [SAMPLE_W-1:0] right_in,
	output logic                       done,
	output logic                       accepted,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	output logic                       refill_request,
	output logic                       is_ready,
	output logic                       has_failed,
	output logic [11:0]                buffered_frames,
	output logic [COUNT_W-1:0]         underrun_count
);

	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [WORD_W-1:0] frame_s1;
	logic              we, re;
	logic [SLOT_W-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;
	result_t           result_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= action;
		frame_s1  <= {right_in, left_in};
	end

	bcaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.action_s1 (action_s1),
		.frame_s1  (frame_s1),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.result_s2 (result_s2)
	);

	bcaf_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done            = result_s2.valid;
	assign accepted        = result_s2.accepted;
	assign left_out        = result_s2.popped ? rdata[SAMPLE_W-1:0] : '0;
	assign right_out       = result_s2.popped ? rdata[WORD_W-1:SAMPLE_W] : '0;
	assign refill_request  = result_s2.refill;
	assign is_ready        = result_s2.ready;
	assign has_failed      = result_s2.failed;
	assign buffered_frames = 12'(result_s2.buffered);
	assign underrun_count  = result_s2.underruns;

	a_refill_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done && refill_request |-> accepted)
		else $error("refill without a popped word");

	a_fail_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done && has_failed |-> !is_ready)
		else $error("ready reported after fault");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result_s2.buffered <= POS_W'(CAPACITY_FRAMES))
		else $error("buffered frames beyond capacity");

	a_pop_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && re |=> result_s2.popped && !has_failed)
		else $error("frame read without popped result");

endmodule

// ===== dv/block_commit_audio_fifo_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the block commit stereo audio fifo
module block_commit_audio_fifo_tb;
	import bcaf_pkg::*;

	localparam logic [1:0] ACT_NOP  = 2'd3;
	localparam int WATCHDOG_CYCLES  = 2000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RANDOM_WORDS     = 1250;
	localparam int IDLE_PERCENT     = 37;

	typedef struct {
		logic                       accepted;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       refill;
		logic                       ready;
		logic                       failed;
		logic [11:0]                frames;
		logic [COUNT_W-1:0]         underruns;
	} fifo_word_t;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       start    = 1'b0;
	logic [1:0]                 action   = ACT_NOP;
	logic signed [SAMPLE_W-1:0] left_in  = '0;
	logic signed [SAMPLE_W-1:0] right_in = '0;
	logic                       busy;
	logic                       done;
	logic                       accepted;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       refill_request;
	logic                       is_ready;
	logic                       has_failed;
	logic [11:0]                buffered_frames;
	logic [COUNT_W-1:0]         underrun_count;

	logic [WORD_W-1:0]  frame_mem [CAPACITY_FRAMES];
	logic [POS_W-1:0]   rd_pos     = '0;
	logic [POS_W-1:0]   commit_pos = '0;
	int                 staged     = 0;
	logic               ready_q    = 1'b0;
	logic               fault_q    = 1'b0;
	logic [COUNT_W-1:0] underrun_q = '0;

	fifo_word_t pending_words[$];
	int         errors       = 0;
	int         quiet_cycles = 0;
	bit         gaps_on      = 1'b1;

	always #5 clk = ~clk;

	block_commit_audio_fifo u_dut (.*);

	function automatic int used_frames();
		logic [POS_W-1:0] diff;
		diff = commit_pos - rd_pos;
		return int'(diff);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		return SAMPLE_W'($urandom());
	endfunction

	function automatic void advance_fifo(logic [1:0] act, logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r);
		fifo_word_t       w;
		int               used;
		logic [POS_W-1:0] wr_pos;
		w = '{default: '0};
		used = used_frames();
		case (act)
			ACT_PUSH: begin
				if (!fault_q && !(staged == 0 && CAPACITY_FRAMES - used < BLOCK_FRAMES)) begin
					wr_pos = commit_pos + POS_W'(staged);
					frame_mem[wr_pos[SLOT_W-1:0]] = {r, l};
					staged++;
					w.accepted = 1'b1;
					if (staged >= BLOCK_FRAMES) begin
						staged = 0;
						commit_pos = commit_pos + POS_W'(BLOCK_FRAMES);
						if (used + BLOCK_FRAMES == CAPACITY_FRAMES)
							ready_q = 1'b1;
					end
				end
			end
			ACT_POP: begin
				if (ready_q && !fault_q) begin
					if (used == 0) begin
						if (underrun_q != '1)
							underrun_q++;
					end else begin
						{w.right, w.left} = frame_mem[rd_pos[SLOT_W-1:0]];
						rd_pos++;
						w.accepted = 1'b1;
						w.refill = (int'(rd_pos) % BLOCK_FRAMES) == 0;
					end
				end
			end
			ACT_FAULT: fault_q = 1'b1;
			default: ;
		endcase
		w.ready = ready_q && !fault_q;
		w.failed = fault_q;
		w.frames = 12'(used_frames());
		w.underruns = underrun_q;
		pending_words.push_back(w);
	endfunction

	function automatic void check_field(string name, logic [COUNT_W-1:0] want,
			logic [COUNT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		fifo_word_t w;
		if (done) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				w = pending_words.pop_front();
				check_field("accepted", w.accepted, accepted);
				check_field("left_out", w.left, left_out);
				check_field("right_out", w.right, right_out);
				check_field("refill_request", w.refill, refill_request);
				check_field("is_ready", w.ready, is_ready);
				check_field("has_failed", w.failed, has_failed);
				check_field("buffered_frames", w.frames, buffered_frames);
				check_field("underrun_count", w.underruns, underrun_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("[block_commit_audio_fifo] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(logic [1:0] act, logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r);
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		left_in <= l;
		right_in <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		advance_fifo(act, l, r);
	endtask

	task automatic send_random(logic [1:0] act);
		send_word(act, rand_sample(), rand_sample());
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	// pops and no-ops before anything is committed
	task automatic test_not_ready();
		send_random(ACT_POP);
		send_random(ACT_NOP);
		send_random(ACT_POP);
	endtask

	task automatic test_sample_extremes();
		send_word(ACT_PUSH, 16'sh7FFF, 16'sh8000);
		send_word(ACT_PUSH, 16'sh8000, 16'sh7FFF);
		send_word(ACT_PUSH, 16'sh0000, 16'sh0000);
		send_word(ACT_PUSH, 16'shFFFF, 16'shFFFF);
		send_word(ACT_PUSH, 16'sh5555, 16'shAAAA);
		send_word(ACT_PUSH, 16'shAAAA, 16'sh5555);
		send_random(ACT_POP);
	endtask

	task automatic test_prefill();
		gaps_on = 1'b0;
		while (!ready_q) begin
			case ($urandom_range(19))
				0: send_random(ACT_POP);
				1: send_random(ACT_NOP);
				default: send_random(ACT_PUSH);
			endcase
		end
		gaps_on = 1'b1;
	endtask

	// buffer full, so a new block has no room
	task automatic test_full_refusal();
		send_random(ACT_PUSH);
		send_random(ACT_NOP);
		send_random(ACT_POP);
		send_random(ACT_PUSH);
	endtask

	task automatic test_drain_underrun();
		while (used_frames() != 0) begin
			if (used_frames() == CAPACITY_FRAMES / 2)
				wait_drained();
			if ($urandom_range(19) == 0)
				send_random(ACT_NOP);
			else
				send_random(ACT_POP);
		end
		repeat (5) send_random(ACT_POP);
		send_random(ACT_PUSH);
		send_random(ACT_POP);
	endtask

	task automatic test_random_traffic();
		int words;
		int kind;
		int burst;
		words = 0;
		while (words < RANDOM_WORDS) begin
			kind = $urandom_range(9);
			burst = ($urandom_range(7) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 64);
			repeat (burst) begin
				if (kind < 5)
					send_random(ACT_PUSH);
				else if (kind < 9)
					send_random(ACT_POP);
				else if ($urandom_range(3) == 0)
					send_random(ACT_NOP);
				else
					send_random($urandom_range(1) ? ACT_PUSH : ACT_POP);
				words++;
			end
		end
	endtask

	task automatic test_fault();
		send_random(ACT_FAULT);
		send_random(ACT_PUSH);
		send_random(ACT_POP);
		send_random(ACT_FAULT);
		send_random(ACT_NOP);
		send_random(ACT_PUSH);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_not_ready();
		test_sample_extremes();
		test_prefill();
		test_full_refusal();
		test_drain_underrun();
		test_random_traffic();
		test_fault();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("[block_commit_audio_fifo] OK");
		else
			$display("[block_commit_audio_fifo] ERROR");
		$finish;
	end

endmodule

// ===== block_commit_audio_fifo.f =====
rtl/bcaf_pkg.sv
rtl/bcaf_ram.sv
rtl/bcaf_ctrl.sv
rtl/block_commit_audio_fifo.sv
dv/block_commit_audio_fifo_tb.sv
